// ----- rtl/core/cmpd_pkg.sv -----
// shared types, constants and fixed-point helpers for the cell move controller
package cmpd_pkg;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WALL_THR,
        REG_PULSES,
        REG_KP_HEAD,
        REG_KD_HEAD,
        REG_KP_WALL,
        REG_KD_WALL,
        REG_KP_ENC,
        REG_KP_FRONT
    } cfg_reg_t;

    localparam logic [12:0] RST_WALL_THR = 13'd100;
    localparam logic [15:0] RST_PULSES   = 16'd500;
    localparam logic [15:0] RST_KP_HEAD  = 16'd896;
    localparam logic [15:0] RST_KD_HEAD  = 16'd51;
    localparam logic [15:0] RST_KP_WALL  = 16'd102;
    localparam logic [15:0] RST_KD_WALL  = 16'd13;
    localparam logic [15:0] RST_KP_ENC   = 16'd128;
    localparam logic [15:0] RST_KP_FRONT = 16'd512;

    // serial divider sizing
    localparam int DIV_W = 54;
    localparam int DEN_W = 20;
    localparam int CNT_W = 6;
    localparam logic [DEN_W-1:0] US_PER_S = 20'd1000000;

    // heading increment: round(p * 256 / 1e6) == floor((4p + 7812) / 15625),
    // done as a multiply by ceil(2^47 / 15625) split into two 17-bit halves
    localparam logic [33:0] HDIV_BIAS = 34'd7812;
    localparam logic [16:0] HREC_LO   = 17'd62487;
    localparam logic [16:0] HREC_HI   = 17'd68719;

    // datapath constants
    localparam logic [15:0]        MIN_DT       = 16'd100;
    localparam logic signed [16:0] ALPHA_Q16    = 17'sd19661;
    localparam logic signed [16:0] OMA_Q16      = 17'sd45875;
    localparam logic signed [14:0] IDEAL_SIDE   = 15'sd45;
    localparam logic signed [18:0] IDEAL_STOP   = 19'sd45;
    localparam logic signed [18:0] DONE_BAND    = 19'sd5;
    localparam logic signed [63:0] TARGET_LIM   = 64'sd655360;
    localparam logic signed [63:0] SPEED_MIN    = -64'sd100;
    localparam logic signed [63:0] SPEED_MAX    = 64'sd150;
    localparam logic signed [63:0] CORR_MAX     = 64'sd511;
    localparam logic signed [63:0] WHEEL_MAX    = 64'sd255;
    localparam int                 PROD_W       = 49;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_PREP,
        OP_HMUL,
        OP_HQUO,
        OP_HEAD,
        OP_DMUL,
        OP_DIV,
        OP_RAW,
        OP_FMUL,
        OP_FSUM,
        OP_TMUL,
        OP_TSUM,
        OP_HERR,
        OP_CMUL,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   head_loop;
    } dp_cmd_t;

    typedef struct packed {
        logic is_start;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_HMUL,
        S_HQUO,
        S_HEAD,
        S_DMUL,
        S_DIV,
        S_DWAIT,
        S_RAW,
        S_FMUL,
        S_FSUM,
        S_TMUL,
        S_TSUM,
        S_HERR,
        S_CMUL,
        S_FIN
    } fsm_state_t;

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // arithmetic right shift, rounding half away from zero
    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int sh);
        logic signed [63:0] half;
        half = 64'sd1 <<< (sh - 1);
        if (v >= 0)
            return (v + half) >>> sh;
        else
            return -((-v + half) >>> sh);
    endfunction

    // arithmetic right shift, truncating toward zero
    function automatic logic signed [63:0] trunc_sh(input logic signed [63:0] v, input int sh);
        if (v >= 0)
            return v >>> sh;
        else
            return -((-v) >>> sh);
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        logic signed [63:0] r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- rtl/core/cmpd_div.sv -----
// restoring serial divider, one quotient bit per cycle, rounds half up on magnitudes
module cmpd_div
    import cmpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] mag,
    input  logic [DEN_W-1:0] den,
    output logic [DIV_W-1:0] quo,
    output logic             done
);

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;

    // load on start, otherwise one shift-subtract step
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[DIV_W-1]};
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            dvd_next = mag + DIV_W'(den >> 1);
            rem_next = '0;
            cnt_next = CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(rem_sh - {1'b0, den_reg});
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= !start && (cnt_reg == CNT_W'(1));
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign quo  = dvd_reg;
    assign done = done_reg;

endmodule

// ----- rtl/core/cmpd_datapath.sv -----
// datapath: config registers, loop state, multipliers, divider and result register
module cmpd_datapath
    import cmpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 func,
    input  logic signed [15:0]   gyro_rate,
    input  logic [12:0]          dist_left,
    input  logic [12:0]          dist_right,
    input  logic [12:0]          dist_front,
    input  logic signed [15:0]   ticks_left,
    input  logic signed [15:0]   ticks_right,
    input  logic [15:0]          elapsed_us,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [8:0]    speed_left,
    output logic signed [8:0]    speed_right,
    output logic                 move_done
);

    // configuration
    logic [12:0] wall_thr_reg;
    logic [15:0] pulses_reg, kp_head_reg, kd_head_reg, kp_wall_reg, kd_wall_reg;
    logic [15:0] kp_enc_reg, kp_front_reg;

    // latched beat
    logic               start_reg;
    logic signed [15:0] gyro_reg, tl_reg, tr_reg;
    logic [12:0]        dl_reg, dr_reg, df_reg;
    logic [15:0]        dt_reg;

    // loop state and working registers
    logic signed [31:0] heading_reg, prev_pe_reg, fpr_reg, prev_he_reg, fhr_reg;
    logic signed [31:0] pe_reg, he_reg, target_reg, raw_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg;
    logic [DIV_W-1:0]   num_mag_reg;
    logic               num_neg_reg, div_neg_reg;
    logic signed [8:0]  base_reg;
    logic               near_done_reg;
    logic [33:0]        hx_reg;
    logic [50:0]        hlo_reg, hhi_reg;
    logic               hneg_reg;
    logic signed [31:0] hinc_reg;

    // result register
    logic               out_valid_reg;
    logic signed [8:0]  sl_reg, sr_reg;
    logic               done_out_reg;

    // combinational values
    logic               front_near, has_l, has_r;
    logic signed [16:0] tsum, avg;
    logic signed [18:0] dist_err;
    logic signed [14:0] pe_int;
    logic signed [31:0] pe_q;
    logic signed [31:0] mx1, mx2;
    logic signed [16:0] my1, my2;
    logic signed [PROD_W-1:0] prod1, prod2;
    logic signed [PROD_W:0]   psum;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [52:0]        num_prod;
    logic [15:0]        gyro_mag;
    logic [31:0]        hmul;
    logic [67:0]        hsum;
    logic [20:0]        hquo;
    logic               div_start;
    logic [DIV_W-1:0]   div_mag, quo;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic signed [DIV_W:0] q_signed;
    logic signed [63:0] q64, corr, sl_w, sr_w;

    cmpd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (div_mag),
        .den   (div_den),
        .quo   (quo),
        .done  (div_done)
    );

    // distance error and base speed operands
    always_comb
    begin
        front_near = df_reg < wall_thr_reg;
        tsum       = 17'(tl_reg) + 17'(tr_reg);
        avg        = tsum[16] ? ((tsum + 17'sd1) >>> 1) : (tsum >>> 1);
        if (front_near)
            dist_err = $signed({6'b0, df_reg}) - IDEAL_STOP;
        else
            dist_err = $signed({3'b0, pulses_reg}) - 19'(avg);
    end

    // wall centering error
    always_comb
    begin
        has_l = dl_reg < wall_thr_reg;
        has_r = dr_reg < wall_thr_reg;
        if (has_l && has_r)
            pe_int = $signed({2'b0, dl_reg}) - $signed({2'b0, dr_reg});
        else if (has_l)
            pe_int = $signed({2'b0, dl_reg}) - IDEAL_SIDE;
        else if (has_r)
            pe_int = IDEAL_SIDE - $signed({2'b0, dr_reg});
        else
            pe_int = '0;
        pe_q = 32'($signed({pe_int, 16'h0}));
    end

    // shared multiplier pair operands
    always_comb
    begin
        mx1 = '0;
        my1 = '0;
        mx2 = '0;
        my2 = '0;
        case (cmd.op)
            OP_PREP:
            begin
                mx1 = 32'(dist_err);
                my1 = $signed({1'b0, front_near ? kp_front_reg : kp_enc_reg});
            end
            OP_FMUL:
            begin
                mx1 = raw_reg;
                my1 = ALPHA_Q16;
                mx2 = cmd.head_loop ? fhr_reg : fpr_reg;
                my2 = OMA_Q16;
            end
            OP_TMUL:
            begin
                mx1 = pe_reg;
                my1 = $signed({1'b0, kp_wall_reg});
                mx2 = fpr_reg;
                my2 = $signed({1'b0, kd_wall_reg});
            end
            OP_CMUL:
            begin
                mx1 = he_reg;
                my1 = $signed({1'b0, kp_head_reg});
                mx2 = fhr_reg;
                my2 = $signed({1'b0, kd_head_reg});
            end
            default:
            begin
                mx1 = '0;
            end
        endcase
        prod1 = mx1 * my1;
        prod2 = mx2 * my2;
        psum  = (PROD_W+1)'(pa_reg) + (PROD_W+1)'(pb_reg);
    end

    // derivative numerator, gyro heading product and divider feed
    always_comb
    begin
        if (cmd.head_loop)
            diff = 33'(he_reg) - 33'(prev_he_reg);
        else
            diff = 33'(pe_reg) - 33'(prev_pe_reg);
        diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
        num_prod  = 53'(diff_mag) * 53'(US_PER_S);
        gyro_mag  = gyro_reg[15] ? 16'(-gyro_reg) : 16'(gyro_reg);
        hmul      = 32'(gyro_mag) * 32'(dt_reg);
        div_start = (cmd.op == OP_DIV);
        div_mag   = num_mag_reg;
        div_den   = DEN_W'(dt_reg);
        q_signed  = div_neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        q64       = 64'(q_signed);
    end

    // heading increment magnitude from the two reciprocal partial products
    always_comb
    begin
        hsum = {hhi_reg, 17'h0} + 68'(hlo_reg);
        hquo = hsum[67:47];
    end

    // steering correction and wheel speeds
    always_comb
    begin
        corr = clamp64(trunc_sh(64'(psum), 24), -CORR_MAX, CORR_MAX);
        sl_w = clamp64(64'(base_reg) - corr, -WHEEL_MAX, WHEEL_MAX);
        sr_w = clamp64(64'(base_reg) + corr, -WHEEL_MAX, WHEEL_MAX);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_thr_reg <= RST_WALL_THR;
            pulses_reg   <= RST_PULSES;
            kp_head_reg  <= RST_KP_HEAD;
            kd_head_reg  <= RST_KD_HEAD;
            kp_wall_reg  <= RST_KP_WALL;
            kd_wall_reg  <= RST_KD_WALL;
            kp_enc_reg   <= RST_KP_ENC;
            kp_front_reg <= RST_KP_FRONT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WALL_THR: wall_thr_reg <= cfg_data[12:0];
                REG_PULSES:   pulses_reg   <= cfg_data;
                REG_KP_HEAD:  kp_head_reg  <= cfg_data;
                REG_KD_HEAD:  kd_head_reg  <= cfg_data;
                REG_KP_WALL:  kp_wall_reg  <= cfg_data;
                REG_KD_WALL:  kd_wall_reg  <= cfg_data;
                REG_KP_ENC:   kp_enc_reg   <= cfg_data;
                REG_KP_FRONT: kp_front_reg <= cfg_data;
                default:      wall_thr_reg <= wall_thr_reg;
            endcase
        end
    end

    // loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg <= '0;
            prev_pe_reg <= '0;
            fpr_reg     <= '0;
            prev_he_reg <= '0;
            fhr_reg     <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_CLEAR:
                begin
                    heading_reg <= '0;
                    prev_pe_reg <= '0;
                    fpr_reg     <= '0;
                    prev_he_reg <= '0;
                    fhr_reg     <= '0;
                end
                OP_HEAD:
                    heading_reg <= sat32(64'(heading_reg) + 64'(hinc_reg));
                OP_DMUL:
                begin
                    if (cmd.head_loop)
                        prev_he_reg <= he_reg;
                    else
                        prev_pe_reg <= pe_reg;
                end
                OP_FSUM:
                begin
                    if (cmd.head_loop)
                        fhr_reg <= sat32(rnd_sh(64'(psum), 16));
                    else
                        fpr_reg <= sat32(rnd_sh(64'(psum), 16));
                end
                default:
                    heading_reg <= heading_reg;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op) inside
            OP_LOAD:
            begin
                start_reg <= func;
                gyro_reg  <= gyro_rate;
                dl_reg    <= dist_left;
                dr_reg    <= dist_right;
                df_reg    <= dist_front;
                tl_reg    <= ticks_left;
                tr_reg    <= ticks_right;
                dt_reg    <= (elapsed_us < MIN_DT) ? MIN_DT : elapsed_us;
            end
            OP_PREP:
            begin
                pa_reg        <= prod1;
                pe_reg        <= pe_q;
                hx_reg        <= {hmul, 2'b00} + HDIV_BIAS;
                hneg_reg      <= gyro_reg[15];
                near_done_reg <= (dist_err > -DONE_BAND) && (dist_err < DONE_BAND);
            end
            OP_HMUL:
            begin
                hlo_reg <= 51'(hx_reg) * 51'(HREC_LO);
                hhi_reg <= 51'(hx_reg) * 51'(HREC_HI);
            end
            OP_HQUO:
                hinc_reg <= hneg_reg ? -$signed({11'b0, hquo}) : $signed({11'b0, hquo});
            OP_HEAD:
                base_reg <= 9'(clamp64(trunc_sh(64'(pa_reg), 8), SPEED_MIN, SPEED_MAX));
            OP_DMUL:
            begin
                num_mag_reg <= DIV_W'(num_prod);
                num_neg_reg <= diff[32];
            end
            OP_DIV:
                div_neg_reg <= num_neg_reg;
            OP_RAW:
                raw_reg <= sat32(q64);
            OP_FMUL, OP_TMUL, OP_CMUL:
            begin
                pa_reg <= prod1;
                pb_reg <= prod2;
            end
            OP_TSUM:
                target_reg <= 32'(clamp64(rnd_sh(64'(psum), 8), -TARGET_LIM, TARGET_LIM));
            OP_HERR:
                he_reg <= sat32(64'(target_reg) - 64'(heading_reg));
            default:
                raw_reg <= raw_reg;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_FINISH || cmd.op == OP_CLEAR)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            sl_reg       <= 9'(sl_w);
            sr_reg       <= 9'(sr_w);
            done_out_reg <= near_done_reg;
        end
        else if (cmd.op == OP_CLEAR)
        begin
            sl_reg       <= '0;
            sr_reg       <= '0;
            done_out_reg <= 1'b0;
        end
    end

    assign stat.is_start = start_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign speed_left  = sl_reg;
    assign speed_right = sr_reg;
    assign move_done   = done_out_reg;

endmodule

// ----- rtl/core/cmpd_ctrl.sv -----
// controller: sequences the datapath through one tick or one begin beat
module cmpd_ctrl
    import cmpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    fsm_state_t state_reg, state_next;
    logic       loop_reg, loop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            loop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            loop_reg  <= loop_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        loop_next     = loop_reg;
        in_ready      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.head_loop = loop_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_start)
                    state_next = S_CLEAR;
                else
                begin
                    cmd.op     = OP_PREP;
                    state_next = S_HMUL;
                end
            end
            S_CLEAR:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_IDLE;
                end
            end
            S_HMUL:
            begin
                cmd.op     = OP_HMUL;
                state_next = S_HQUO;
            end
            S_HQUO:
            begin
                cmd.op     = OP_HQUO;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.op     = OP_HEAD;
                loop_next  = 1'b0;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.op     = OP_DMUL;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op     = OP_DIV;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (stat.div_done)
                    state_next = S_RAW;
            end
            S_RAW:
            begin
                cmd.op     = OP_RAW;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.op     = OP_FMUL;
                state_next = S_FSUM;
            end
            S_FSUM:
            begin
                cmd.op     = OP_FSUM;
                state_next = loop_reg ? S_CMUL : S_TMUL;
            end
            S_TMUL:
            begin
                cmd.op     = OP_TMUL;
                state_next = S_TSUM;
            end
            S_TSUM:
            begin
                cmd.op     = OP_TSUM;
                state_next = S_HERR;
            end
            S_HERR:
            begin
                cmd.op     = OP_HERR;
                loop_next  = 1'b1;
                state_next = S_DMUL;
            end
            S_CMUL:
            begin
                cmd.op     = OP_CMUL;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/cell_move_cascaded_pd_controller.sv -----
// top level: cascaded PD cell move controller, controller plus datapath
//
// One input beat gives one result beat. A control tick integrates the gyro into a
// heading, runs the filtered wall-centering PD loop into a target heading and the
// filtered heading PD loop into a steering correction, and returns the saturated
// wheel speeds with a done flag; a begin beat clears the loop state and returns
// zeros. Beats are handled one at a time; a control tick makes two passes through
// the one shared serial divider (the two derivative rates), and the heading
// increment is a reciprocal multiply. The result sits in an output register, so
// the next beat is taken while it waits. Config writes are taken at any edge with
// cfg_we high and belong in idle periods.
module cell_move_cascaded_pd_controller
    import cmpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic signed [15:0]   gyro_rate,
    input  logic [12:0]          dist_left,
    input  logic [12:0]          dist_right,
    input  logic [12:0]          dist_front,
    input  logic signed [15:0]   ticks_left,
    input  logic signed [15:0]   ticks_right,
    input  logic [15:0]          elapsed_us,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [8:0]    speed_left,
    output logic signed [8:0]    speed_right,
    output logic                 move_done
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cmpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cmpd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .gyro_rate   (gyro_rate),
        .dist_left   (dist_left),
        .dist_right  (dist_right),
        .dist_front  (dist_front),
        .ticks_left  (ticks_left),
        .ticks_right (ticks_right),
        .elapsed_us  (elapsed_us),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .speed_left  (speed_left),
        .speed_right (speed_right),
        .move_done   (move_done)
    );

endmodule
